// ===== rtl/two_opt_tour_search_top_macros.svh =====
// Assertion macros used by the two-opt tour search top level.
`ifndef TWO_OPT_TOUR_SEARCH_TOP_MACROS_SVH
`define TWO_OPT_TOUR_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
// Check cons in the same cycle whenever ante holds.
`define TOTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante holds.
`define TOTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TOTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define TOTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/tots_pkg.sv =====
// Types and constants shared by the two-opt tour search modules.
package tots_pkg;

    localparam int COST_W = 24;
    localparam int CITY_W = 8;
    localparam logic [23:0] COST_MAX = 24'hFFFFFF;
    localparam logic [24:0] NO_CAND = 25'h1FFFFFF;
    localparam logic [8:0] DEF_CITIES = 9'd256;
    localparam logic [15:0] DEF_STALL_LIMIT = 16'd20000;
    localparam logic [15:0] STALL_SAT = 16'hFFFF;

    localparam logic [2:0] FN_LOAD_DIST = 3'd0;
    localparam logic [2:0] FN_LOAD_CITY = 3'd1;
    localparam logic [2:0] FN_COST = 3'd2;
    localparam logic [2:0] FN_OFFER = 3'd3;
    localparam logic [2:0] FN_COMMIT = 3'd4;
    localparam logic [2:0] FN_READ_BEST = 3'd5;

    localparam logic CFG_NUM_CITIES = 1'b0;
    localparam logic CFG_STALL_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        RS_K, RS_PREV, RS_A, RS_B, RS_NEXT, RS_LO, RS_HI
    } rd_sel_t;

    typedef enum logic [2:0] {
        LS_NONE, LS_TP, LS_TA, LS_TB, LS_TN, LS_TLO
    } latch_sel_t;

    typedef enum logic [2:0] {
        DS_SWEEP, DS_WRAP, DS_PA, DS_PB, DS_BN, DS_AN
    } dist_sel_t;

    typedef enum logic [1:0] {
        MV_HOLD, MV_INIT, MV_SUB, MV_ADD
    } mv_op_t;

    typedef enum logic [1:0] {
        CW_NONE, CW_IN, CW_LO, CW_HI
    } cur_wr_t;

    typedef struct packed {
        logic       capture;
        logic       dist_wr;
        cur_wr_t    cur_wr;
        rd_sel_t    rd_sel;
        latch_sel_t latch;
        dist_sel_t  dist_sel;
        mv_op_t     mv_op;
        logic       sweep_start;
        logic       sweep_run;
        logic       cost_fin;
        logic       offer_fin;
        logic       commit_decide;
        logic       rev_step;
        logic       commit_post;
        logic       city_out;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       offer_walk;
        logic       sweep_done;
        logic       rev_more;
        logic       improve_now;
    } sts_t;

endpackage

// ===== rtl/two_opt_tour_search_top.sv =====
// Top level of the two-opt tour search engine.
// Two-opt tour search engine. The host loads a symmetric distance table (func 0,
// one entry per request, both halves) and the tour cities (func 1), then
// starts a run with a full cyclic cost pass (func 2), which also copies the
// current tour to the best tour, clears the stall counter and empties the
// batch. It then offers 2-opt moves (func 3, reverse positions a..b) and
// commits each batch (func 4); the earliest strictly cheapest offer of a batch
// is kept. A commit applies an improving move, or a worse one when
// accept_worse is set, and refreshes the best tour and stall counter. Func 5
// reads a city of the best tour. Every request returns exactly one result with
// both costs and the stalled flag. One request is worked at a time: a general
// offer makes four reads of the tour memory, then four reads of the distance
// memory, while an invalid or whole-tour offer makes none; a cost pass is a
// pipelined sweep over all 256 tour slots; a commit swaps the reversed
// segment pair by pair and, when the best tour improves, copies the current
// tour to the best tour with another sweep. A new request is taken while the
// previous result still waits on m_ready. Distance and tour memories come up
// unwritten and are never cleared.
`include "two_opt_tour_search_top_macros.svh"

module two_opt_tour_search_top #(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_index_a,
    input  logic [7:0]  s_index_b,
    input  logic [15:0] s_value,
    input  logic        s_accept_worse,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_city,
    output logic [23:0] m_move_cost,
    output logic [23:0] m_current_cost_out,
    output logic [23:0] m_best_cost_out,
    output logic        m_move_applied,
    output logic        m_best_improved,
    output logic        m_stalled,
    // configuration writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    tots_pkg::cmd_t cmd;
    tots_pkg::sts_t sts;

    // Sequence each request through the datapath.
    tots_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the memories, costs, batch and output register.
    tots_datapath #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_func             (s_func),
        .s_index_a          (s_index_a),
        .s_index_b          (s_index_b),
        .s_value            (s_value),
        .s_accept_worse     (s_accept_worse),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .m_read_city        (m_read_city),
        .m_move_cost        (m_move_cost),
        .m_current_cost_out (m_current_cost_out),
        .m_best_cost_out    (m_best_cost_out),
        .m_move_applied     (m_move_applied),
        .m_best_improved    (m_best_improved),
        .m_stalled          (m_stalled)
    );

    // One request in flight: after acceptance, drop ready.
    `TOTS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready high right after a request was accepted")
    // Never overwrite a result that has not been taken.
    `TOTS_ASSERT_NOW(a_out_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready, "result register overwritten while still pending")
    // A distance load never coincides with tour writes or a sweep.
    `TOTS_ASSERT_NOW(a_dist_wr_alone, aclk, aresetn, cmd.dist_wr, (cmd.cur_wr == tots_pkg::CW_NONE) && !cmd.sweep_run, "distance write overlaps tour activity")

endmodule

// ===== rtl/tots_datapath.sv =====
// Datapath of the two-opt tour search: memories, cost arithmetic and registers.
module tots_datapath #(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tots_pkg::cmd_t       cmd,
    output tots_pkg::sts_t       sts,
    input  logic [2:0]           s_func,
    input  logic [7:0]           s_index_a,
    input  logic [7:0]           s_index_b,
    input  logic [15:0]          s_value,
    input  logic                 s_accept_worse,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    output logic [7:0]           m_read_city,
    output logic [23:0]          m_move_cost,
    output logic [23:0]          m_current_cost_out,
    output logic [23:0]          m_best_cost_out,
    output logic                 m_move_applied,
    output logic                 m_best_improved,
    output logic                 m_stalled
);

    localparam int EFF_MAX = (MAX_CITIES < 256) ? MAX_CITIES : 256;

    // item registers
    logic [2:0]  func_reg;
    logic [7:0]  a_reg, b_reg;
    logic [15:0] value_reg;
    logic        accept_reg;

    logic [8:0]  num_cities_reg;
    logic [15:0] stall_limit_reg;

    logic [23:0] cur_cost_reg, best_cost_reg;
    logic [24:0] batch_cost_reg;
    logic [7:0]  batch_start_reg, batch_end_reg;
    logic [15:0] stall_reg;

    logic [DIST_BITS-1:0] dist_mem [65536];
    logic [7:0]           cur_mem [256];
    logic [7:0]           best_mem [256];
    logic [DIST_BITS-1:0] dist_rdata_reg;
    logic [7:0]           cur_rdata_reg, best_rdata_reg;

    logic [8:0]  k_reg;
    logic        p1_valid_reg, p2_valid_reg;
    logic [7:0]  p1_idx_reg;
    logic [7:0]  prev_city_reg, first_city_reg;
    logic [23:0] acc_reg;

    logic [7:0]  tp_reg, ta_reg, tb_reg, tn_reg, tlo_reg;
    logic signed [26:0] mv_reg;

    logic [7:0]  lo_reg, hi_reg;
    logic        apply_reg, applied_reg, improved_reg;
    logic [23:0] move_cost_reg;
    logic [7:0]  read_city_reg;

    logic [7:0]  out_city_reg;
    logic [23:0] out_move_reg, out_cur_reg, out_best_reg;
    logic        out_applied_reg, out_improved_reg, out_stalled_reg;

    logic [8:0]  n_cities, nm1;
    logic        offer_ok, offer_whole;
    logic [7:0]  prev_pos, next_pos;
    logic [7:0]  cur_rd_addr;
    logic        cur_we;
    logic [7:0]  cur_waddr, cur_wdata;
    logic [15:0] dist_rd_addr;
    logic [23:0] dist_ext;
    logic [24:0] acc_sum;
    logic [23:0] acc_sat;
    logic [23:0] mv_sat, offer_cost;
    logic        cand, improving, apply_now, improve_now;

    assign n_cities = (num_cities_reg > 9'(EFF_MAX)) ? 9'(EFF_MAX) : num_cities_reg;
    assign nm1 = n_cities - 9'd1;
    assign offer_ok = (a_reg < b_reg) && ({1'b0, b_reg} < n_cities);
    assign offer_whole = (a_reg == 8'd0) && ({1'b0, b_reg} == nm1);
    assign prev_pos = (a_reg == 8'd0) ? nm1[7:0] : a_reg - 8'd1;
    assign next_pos = (({1'b0, b_reg} + 9'd1) == n_cities) ? 8'd0 : b_reg + 8'd1;

    assign dist_ext = 24'(dist_rdata_reg);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, dist_ext};
    assign acc_sat = acc_sum[24] ? tots_pkg::COST_MAX : acc_sum[23:0];

    assign mv_sat = mv_reg[26] ? 24'd0 :
                    (mv_reg > 27'sd16777215) ? tots_pkg::COST_MAX : mv_reg[23:0];
    assign offer_cost = offer_whole ? cur_cost_reg : mv_sat;

    assign cand = (batch_cost_reg != tots_pkg::NO_CAND);
    assign improving = cand && (batch_cost_reg < {1'b0, cur_cost_reg});
    assign apply_now = improving || (cand && accept_reg);
    assign improve_now = apply_reg && (batch_cost_reg[23:0] < best_cost_reg);

    assign sts.func = func_reg;
    assign sts.offer_walk = offer_ok && !offer_whole;
    assign sts.sweep_done = k_reg[8] && !p1_valid_reg && !p2_valid_reg;
    assign sts.rev_more = apply_reg && (lo_reg < hi_reg);
    assign sts.improve_now = improve_now;

    always_comb begin
        case (cmd.rd_sel)
            tots_pkg::RS_K:    cur_rd_addr = k_reg[7:0];
            tots_pkg::RS_PREV: cur_rd_addr = prev_pos;
            tots_pkg::RS_A:    cur_rd_addr = a_reg;
            tots_pkg::RS_B:    cur_rd_addr = b_reg;
            tots_pkg::RS_NEXT: cur_rd_addr = next_pos;
            tots_pkg::RS_LO:   cur_rd_addr = lo_reg;
            tots_pkg::RS_HI:   cur_rd_addr = hi_reg;
            default:           cur_rd_addr = a_reg;
        endcase
    end

    always_comb begin
        case (cmd.dist_sel)
            tots_pkg::DS_SWEEP: dist_rd_addr = {prev_city_reg, cur_rdata_reg};
            tots_pkg::DS_WRAP:  dist_rd_addr = {prev_city_reg, first_city_reg};
            tots_pkg::DS_PA:    dist_rd_addr = {tp_reg, ta_reg};
            tots_pkg::DS_PB:    dist_rd_addr = {tp_reg, tb_reg};
            tots_pkg::DS_BN:    dist_rd_addr = {tb_reg, tn_reg};
            tots_pkg::DS_AN:    dist_rd_addr = {ta_reg, tn_reg};
            default:            dist_rd_addr = {tp_reg, ta_reg};
        endcase
    end

    always_comb begin
        case (cmd.cur_wr)
            tots_pkg::CW_IN: begin
                cur_we = 1'b1;
                cur_waddr = a_reg;
                cur_wdata = value_reg[7:0];
            end
            tots_pkg::CW_LO: begin
                cur_we = 1'b1;
                cur_waddr = lo_reg;
                cur_wdata = cur_rdata_reg;
            end
            tots_pkg::CW_HI: begin
                cur_we = 1'b1;
                cur_waddr = hi_reg;
                cur_wdata = tlo_reg;
            end
            default: begin
                cur_we = 1'b0;
                cur_waddr = a_reg;
                cur_wdata = value_reg[7:0];
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.dist_wr) begin
            dist_mem[{a_reg, b_reg}] <= DIST_BITS'(value_reg);
        end
        dist_rdata_reg <= dist_mem[dist_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rdata_reg <= cur_mem[cur_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            best_mem[p1_idx_reg] <= cur_rdata_reg;
        end
        best_rdata_reg <= best_mem[a_reg];
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cities_reg <= tots_pkg::DEF_CITIES;
            stall_limit_reg <= tots_pkg::DEF_STALL_LIMIT;
        end else if (cfg_we) begin
            if (cfg_index == tots_pkg::CFG_NUM_CITIES) begin
                num_cities_reg <= cfg_wdata[8:0];
            end else begin
                stall_limit_reg <= cfg_wdata;
            end
        end
    end

    // tour state, batch and stall counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_cost_reg <= '0;
            best_cost_reg <= '0;
            batch_cost_reg <= tots_pkg::NO_CAND;
            batch_start_reg <= '0;
            batch_end_reg <= '0;
            stall_reg <= '0;
            apply_reg <= 1'b0;
        end else begin
            if (cmd.cost_fin) begin
                cur_cost_reg <= (n_cities != 9'd0) ? acc_sat : acc_reg;
                best_cost_reg <= (n_cities != 9'd0) ? acc_sat : acc_reg;
                stall_reg <= '0;
                batch_cost_reg <= tots_pkg::NO_CAND;
            end
            if (cmd.offer_fin && offer_ok && ({1'b0, offer_cost} < batch_cost_reg)) begin
                batch_cost_reg <= {1'b0, offer_cost};
                batch_start_reg <= a_reg;
                batch_end_reg <= b_reg;
            end
            if (cmd.commit_decide) begin
                apply_reg <= apply_now;
                if (!improving && stall_reg != tots_pkg::STALL_SAT) begin
                    stall_reg <= stall_reg + 16'd1;
                end
            end
            if (cmd.commit_post) begin
                if (apply_reg) begin
                    cur_cost_reg <= batch_cost_reg[23:0];
                end
                if (improve_now) begin
                    best_cost_reg <= batch_cost_reg[23:0];
                    stall_reg <= '0;
                end
                batch_cost_reg <= tots_pkg::NO_CAND;
            end
        end
    end

    // sweep pipeline: tour read, then distance read, then accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 9'h100;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (cmd.sweep_start) begin
            k_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.sweep_run && !k_reg[8];
            p2_valid_reg <= p1_valid_reg && (p1_idx_reg != 8'd0)
                            && ({1'b0, p1_idx_reg} < n_cities);
            if (cmd.sweep_run && !k_reg[8]) begin
                k_reg <= k_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg <= k_reg[7:0];
        if (cmd.sweep_start) begin
            acc_reg <= '0;
        end else if (p2_valid_reg) begin
            acc_reg <= acc_sat;
        end
        if (p1_valid_reg) begin
            if (p1_idx_reg == 8'd0) begin
                first_city_reg <= cur_rdata_reg;
            end
            if ({1'b0, p1_idx_reg} < n_cities) begin
                prev_city_reg <= cur_rdata_reg;
            end
        end
        case (cmd.latch)
            tots_pkg::LS_TP:  tp_reg <= cur_rdata_reg;
            tots_pkg::LS_TA:  ta_reg <= cur_rdata_reg;
            tots_pkg::LS_TB:  tb_reg <= cur_rdata_reg;
            tots_pkg::LS_TN:  tn_reg <= cur_rdata_reg;
            tots_pkg::LS_TLO: tlo_reg <= cur_rdata_reg;
            default: ;
        endcase
        case (cmd.mv_op)
            tots_pkg::MV_INIT: mv_reg <= signed'({3'b000, cur_cost_reg});
            tots_pkg::MV_SUB:  mv_reg <= mv_reg - signed'({3'b000, dist_ext});
            tots_pkg::MV_ADD:  mv_reg <= mv_reg + signed'({3'b000, dist_ext});
            default: ;
        endcase
        if (cmd.commit_decide) begin
            lo_reg <= batch_start_reg;
            hi_reg <= batch_end_reg;
        end else if (cmd.rev_step) begin
            lo_reg <= lo_reg + 8'd1;
            hi_reg <= hi_reg - 8'd1;
        end
    end

    // per-item request capture and result flags
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            a_reg <= s_index_a;
            b_reg <= s_index_b;
            value_reg <= s_value;
            accept_reg <= s_accept_worse;
            applied_reg <= 1'b0;
            improved_reg <= 1'b0;
            move_cost_reg <= '0;
            read_city_reg <= '0;
        end else begin
            if (cmd.offer_fin) begin
                move_cost_reg <= offer_ok ? offer_cost : tots_pkg::COST_MAX;
            end
            if (cmd.commit_decide) begin
                applied_reg <= apply_now;
            end
            if (cmd.commit_post && improve_now) begin
                improved_reg <= 1'b1;
            end
            if (cmd.city_out) begin
                read_city_reg <= best_rdata_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_city_reg <= read_city_reg;
            out_move_reg <= move_cost_reg;
            out_cur_reg <= cur_cost_reg;
            out_best_reg <= best_cost_reg;
            out_applied_reg <= applied_reg;
            out_improved_reg <= improved_reg;
            out_stalled_reg <= (stall_reg >= stall_limit_reg);
        end
    end

    assign m_read_city = out_city_reg;
    assign m_move_cost = out_move_reg;
    assign m_current_cost_out = out_cur_reg;
    assign m_best_cost_out = out_best_reg;
    assign m_move_applied = out_applied_reg;
    assign m_best_improved = out_improved_reg;
    assign m_stalled = out_stalled_reg;

endmodule

// ===== rtl/tots_controller.sv =====
// Sequencing state machine of the two-opt tour search.
module tots_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  tots_pkg::sts_t sts,
    output tots_pkg::cmd_t cmd
);

    typedef enum logic [20:0] {
        ST_IDLE  = 21'b1 << 0,
        ST_EXEC  = 21'b1 << 1,
        ST_SWEEP = 21'b1 << 2,
        ST_WRAP  = 21'b1 << 3,
        ST_WRAP2 = 21'b1 << 4,
        ST_OF0   = 21'b1 << 5,
        ST_OF1   = 21'b1 << 6,
        ST_OF2   = 21'b1 << 7,
        ST_OF3   = 21'b1 << 8,
        ST_OF4   = 21'b1 << 9,
        ST_OF5   = 21'b1 << 10,
        ST_OF6   = 21'b1 << 11,
        ST_OF7   = 21'b1 << 12,
        ST_OFIN  = 21'b1 << 13,
        ST_RV0   = 21'b1 << 14,
        ST_RV1   = 21'b1 << 15,
        ST_RV2   = 21'b1 << 16,
        ST_RV3   = 21'b1 << 17,
        ST_CPOST = 21'b1 << 18,
        ST_RDB   = 21'b1 << 19,
        ST_DONE  = 21'b1 << 20
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (sts.func)
                    tots_pkg::FN_LOAD_DIST: begin
                        cmd.dist_wr = 1'b1;
                        state_next = ST_DONE;
                    end
                    tots_pkg::FN_LOAD_CITY: begin
                        cmd.cur_wr = tots_pkg::CW_IN;
                        state_next = ST_DONE;
                    end
                    tots_pkg::FN_COST: begin
                        cmd.sweep_start = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    tots_pkg::FN_OFFER: begin
                        state_next = sts.offer_walk ? ST_OF0 : ST_OFIN;
                    end
                    tots_pkg::FN_COMMIT: begin
                        cmd.commit_decide = 1'b1;
                        state_next = ST_RV0;
                    end
                    tots_pkg::FN_READ_BEST: begin
                        state_next = ST_RDB;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SWEEP: begin
                cmd.sweep_run = 1'b1;
                cmd.rd_sel = tots_pkg::RS_K;
                cmd.dist_sel = tots_pkg::DS_SWEEP;
                if (sts.sweep_done) begin
                    state_next = (sts.func == tots_pkg::FN_COMMIT) ? ST_DONE : ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.dist_sel = tots_pkg::DS_WRAP;
                state_next = ST_WRAP2;
            end
            ST_WRAP2: begin
                cmd.cost_fin = 1'b1;
                state_next = ST_DONE;
            end
            ST_OF0: begin
                cmd.rd_sel = tots_pkg::RS_PREV;
                state_next = ST_OF1;
            end
            ST_OF1: begin
                cmd.rd_sel = tots_pkg::RS_A;
                cmd.latch = tots_pkg::LS_TP;
                cmd.mv_op = tots_pkg::MV_INIT;
                state_next = ST_OF2;
            end
            ST_OF2: begin
                cmd.rd_sel = tots_pkg::RS_B;
                cmd.latch = tots_pkg::LS_TA;
                state_next = ST_OF3;
            end
            ST_OF3: begin
                cmd.rd_sel = tots_pkg::RS_NEXT;
                cmd.latch = tots_pkg::LS_TB;
                cmd.dist_sel = tots_pkg::DS_PA;
                state_next = ST_OF4;
            end
            ST_OF4: begin
                cmd.latch = tots_pkg::LS_TN;
                cmd.dist_sel = tots_pkg::DS_PB;
                cmd.mv_op = tots_pkg::MV_SUB;
                state_next = ST_OF5;
            end
            ST_OF5: begin
                cmd.dist_sel = tots_pkg::DS_BN;
                cmd.mv_op = tots_pkg::MV_ADD;
                state_next = ST_OF6;
            end
            ST_OF6: begin
                cmd.dist_sel = tots_pkg::DS_AN;
                cmd.mv_op = tots_pkg::MV_SUB;
                state_next = ST_OF7;
            end
            ST_OF7: begin
                cmd.mv_op = tots_pkg::MV_ADD;
                state_next = ST_OFIN;
            end
            ST_OFIN: begin
                cmd.offer_fin = 1'b1;
                state_next = ST_DONE;
            end
            ST_RV0: begin
                cmd.rd_sel = tots_pkg::RS_LO;
                state_next = sts.rev_more ? ST_RV1 : ST_CPOST;
            end
            ST_RV1: begin
                cmd.rd_sel = tots_pkg::RS_HI;
                cmd.latch = tots_pkg::LS_TLO;
                state_next = ST_RV2;
            end
            ST_RV2: begin
                cmd.cur_wr = tots_pkg::CW_LO;
                state_next = ST_RV3;
            end
            ST_RV3: begin
                cmd.cur_wr = tots_pkg::CW_HI;
                cmd.rev_step = 1'b1;
                state_next = ST_RV0;
            end
            ST_CPOST: begin
                cmd.commit_post = 1'b1;
                if (sts.improve_now) begin
                    cmd.sweep_start = 1'b1;
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RDB: begin
                cmd.city_out = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== bench/two_opt_tour_search_top_tb.sv =====
// Self-checking testbench for the two-opt tour search engine.
`timescale 1ns / 100ps

module two_opt_tour_search_top_tb;

    // Function codes with no operation behind them
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] value;
        logic        accept;
    } tour_req_t;

    typedef struct {
        logic [7:0]  city;
        logic [23:0] mcost;
        logic [23:0] cur;
        logic [23:0] best;
        logic        applied;
        logic        improved;
        logic        stalled;
    } tour_res_t;

    // One row of the directed part; typed rows carry a hand-written result
    typedef struct {
        tour_req_t req;
        bit        typed;
        tour_res_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [7:0]  s_index_a = '0;
    logic [7:0]  s_index_b = '0;
    logic [15:0] s_value = '0;
    logic        s_accept_worse = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_city;
    logic [23:0] m_move_cost;
    logic [23:0] m_current_cost_out;
    logic [23:0] m_best_cost_out;
    logic        m_move_applied;
    logic        m_best_improved;
    logic        m_stalled;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    two_opt_tour_search_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_index_a(s_index_a), .s_index_b(s_index_b), .s_value(s_value),
        .s_accept_worse(s_accept_worse),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_city(m_read_city),
        .m_move_cost(m_move_cost), .m_current_cost_out(m_current_cost_out),
        .m_best_cost_out(m_best_cost_out), .m_move_applied(m_move_applied),
        .m_best_improved(m_best_improved), .m_stalled(m_stalled),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the engine state
    logic [15:0] dist_shadow [0:65535];
    logic [7:0]  cur_tour [0:255];
    logic [7:0]  best_tour [0:255];
    logic [23:0] cur_cost;
    logic [23:0] best_cost;
    logic [24:0] batch_cost;
    logic [7:0]  batch_lo;
    logic [7:0]  batch_hi;
    logic [15:0] stall_cnt;
    logic [8:0]  city_count;
    logic [15:0] stall_limit;

    // Only these cities ever enter a tour, and all their pairs are loaded,
    // so no distance read can land on an unwritten entry.
    logic [7:0]  city_set [0:15];

    tour_res_t   pending_q [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          commits_sent = 0;
    int          offers_sent = 0;

    function automatic logic [15:0] pair_dist(int p, int q);
        return dist_shadow[{cur_tour[p], cur_tour[q]}];
    endfunction

    function automatic logic [23:0] clamp_cost(longint v);
        if (v < 0) return 24'd0;
        if (v > longint'(tots_pkg::COST_MAX)) return tots_pkg::COST_MAX;
        return v[23:0];
    endfunction

    // Advance the shadow state by one request and return the result it causes
    function automatic tour_res_t predict_step(tour_req_t r);
        tour_res_t res;
        int n;
        int lo;
        int hi;
        int prv;
        int nxt;
        longint sum;
        logic [7:0] t;
        logic [23:0] c;
        bit apply;
        res = '{default: '0};
        n = (city_count > 256) ? 256 : int'(city_count);
        case (r.func)
            tots_pkg::FN_LOAD_DIST: dist_shadow[{r.a, r.b}] = r.value;
            tots_pkg::FN_LOAD_CITY: cur_tour[r.a] = r.value[7:0];
            tots_pkg::FN_COST: begin
                sum = 0;
                for (int i = 0; i < n; i++) begin
                    sum += longint'(pair_dist(i, (i + 1 == n) ? 0 : i + 1));
                    if (sum > longint'(tots_pkg::COST_MAX)) sum = tots_pkg::COST_MAX;
                end
                cur_cost = clamp_cost(sum);
                best_cost = cur_cost;
                best_tour = cur_tour;
                stall_cnt = '0;
                batch_cost = tots_pkg::NO_CAND;
            end
            tots_pkg::FN_OFFER: begin
                if (r.a < r.b && int'(r.b) < n) begin
                    if (r.a == 0 && int'(r.b) == n - 1) begin
                        c = cur_cost;
                    end else begin
                        prv = (r.a == 0) ? n - 1 : int'(r.a) - 1;
                        nxt = (int'(r.b) + 1 == n) ? 0 : int'(r.b) + 1;
                        c = clamp_cost(longint'(cur_cost)
                            - longint'(pair_dist(prv, int'(r.a)))
                            - longint'(pair_dist(int'(r.b), nxt))
                            + longint'(pair_dist(prv, int'(r.b)))
                            + longint'(pair_dist(int'(r.a), nxt)));
                    end
                    res.mcost = c;
                    if ({1'b0, c} < batch_cost) begin
                        batch_cost = {1'b0, c};
                        batch_lo = r.a;
                        batch_hi = r.b;
                    end
                end else begin
                    res.mcost = tots_pkg::COST_MAX;
                end
            end
            tots_pkg::FN_COMMIT: begin
                apply = 1'b0;
                if (batch_cost != tots_pkg::NO_CAND && batch_cost < {1'b0, cur_cost}) begin
                    apply = 1'b1;
                end else begin
                    if (stall_cnt != tots_pkg::STALL_SAT) stall_cnt++;
                    if (batch_cost != tots_pkg::NO_CAND && r.accept) apply = 1'b1;
                end
                if (apply) begin
                    lo = int'(batch_lo);
                    hi = int'(batch_hi);
                    while (lo < hi) begin
                        t = cur_tour[lo];
                        cur_tour[lo] = cur_tour[hi];
                        cur_tour[hi] = t;
                        lo++;
                        hi--;
                    end
                    cur_cost = batch_cost[23:0];
                    res.applied = 1'b1;
                    if (cur_cost < best_cost) begin
                        best_cost = cur_cost;
                        best_tour = cur_tour;
                        stall_cnt = '0;
                        res.improved = 1'b1;
                    end
                end
                batch_cost = tots_pkg::NO_CAND;
            end
            tots_pkg::FN_READ_BEST: res.city = best_tour[r.a];
            default: ;
        endcase
        res.cur = cur_cost;
        res.best = best_cost;
        res.stalled = (stall_cnt >= stall_limit);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h want %0h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // Present one request after a random gap; hold it until the engine takes it
    task automatic send_req(tour_req_t r, bit typed = 1'b0, tour_res_t want = '{default: '0});
        int gap;
        tour_res_t predicted;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= r.func;
        s_index_a <= r.a;
        s_index_b <= r.b;
        s_value <= r.value;
        s_accept_worse <= r.accept;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_step(r);
        if (typed) predicted = want;
        pending_q = {pending_q, predicted};
        if (r.func == tots_pkg::FN_COMMIT) commits_sent++;
        if (r.func == tots_pkg::FN_OFFER) offers_sent++;
        @(negedge aclk);
    endtask

    function automatic tour_req_t mk_req(logic [2:0] f, logic [7:0] a, logic [7:0] b,
                                         logic [15:0] v, logic acc);
        tour_req_t r;
        r.func = f;
        r.a = a;
        r.b = b;
        r.value = v;
        r.accept = acc;
        return r;
    endfunction

    task automatic add_row(tour_req_t r, bit typed = 1'b0, tour_res_t want = '{default: '0});
        dir_row_t row;
        row.req = r;
        row.typed = typed;
        row.want = want;
        dir_rows = {dir_rows, row};
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == tots_pkg::CFG_NUM_CITIES) city_count = data[8:0];
        else stall_limit = data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Build a random request, weighted toward well-formed offer/commit batches
    function automatic tour_req_t random_req();
        int n;
        int pick;
        logic [7:0] a;
        logic [7:0] b;
        n = (city_count > 256) ? 256 : int'(city_count);
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
            a = 8'($urandom_range(0, n - 2));
            b = 8'($urandom_range(int'(a) + 1, n - 1));
            return mk_req(tots_pkg::FN_OFFER, a, b, 16'($urandom), 1'($urandom));
        end else if (pick < 74) begin
            // offer that is often malformed: reversed, equal, or past the tour end
            a = 8'($urandom);
            if ($urandom_range(0, 1) == 1 || a == 8'hFF)
                b = 8'(int'(a) - int'($urandom_range(0, int'(a))));
            else
                b = 8'($urandom_range(int'(a), 255));
            return mk_req(tots_pkg::FN_OFFER, a, b, 16'($urandom), 1'($urandom));
        end else if (pick < 87) begin
            return mk_req(tots_pkg::FN_COMMIT, 8'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
            return mk_req(tots_pkg::FN_LOAD_DIST, city_set[4'($urandom_range(0, 15))],
                          city_set[4'($urandom_range(0, 15))],
                          $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom), 1'b0);
        end else if (pick < 92) begin
            // stray write, almost always outside the used city pairs
            return mk_req(tots_pkg::FN_LOAD_DIST, 8'($urandom), 8'($urandom),
                          16'($urandom), 1'($urandom));
        end else if (pick < 94) begin
            return mk_req(tots_pkg::FN_LOAD_CITY, 8'($urandom), 8'($urandom),
                          {8'($urandom), city_set[4'($urandom_range(0, 15))]},
                          1'($urandom));
        end else if (pick < 97) begin
            return mk_req(tots_pkg::FN_READ_BEST, 8'($urandom), 8'($urandom),
                          16'($urandom), 1'($urandom));
        end else if (pick < 98) begin
            return mk_req(tots_pkg::FN_COST, 8'($urandom), 8'($urandom),
                          16'($urandom), 1'($urandom));
        end
        return mk_req($urandom_range(0, 1) == 1 ? FN_SPARE6 : FN_SPARE7, 8'($urandom),
                      8'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    // Result side: stall a random number of cycles, then check one result
    initial begin : result_monitor
        int stall;
        tour_res_t want;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = pending_q.pop_front();
                if (m_read_city !== want.city)
                    report_mismatch("read_city", m_read_city, want.city);
                if (m_move_cost !== want.mcost)
                    report_mismatch("move_cost", m_move_cost, want.mcost);
                if (m_current_cost_out !== want.cur)
                    report_mismatch("current_cost", m_current_cost_out, want.cur);
                if (m_best_cost_out !== want.best)
                    report_mismatch("best_cost", m_best_cost_out, want.best);
                if (m_move_applied !== want.applied)
                    report_mismatch("move_applied", m_move_applied, want.applied);
                if (m_best_improved !== want.improved)
                    report_mismatch("best_improved", m_best_improved, want.improved);
                if (m_stalled !== want.stalled)
                    report_mismatch("stalled", m_stalled, want.stalled);
            end
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        tour_res_t zero_res;
        tour_res_t sat_res;
        logic [15:0] d;
        logic [15:0] lim;
        logic [8:0] cities;
        zero_res = '{default: '0};
        sat_res = zero_res;
        sat_res.mcost = tots_pkg::COST_MAX;

        // reset shadow state
        cur_cost = '0;
        best_cost = '0;
        batch_cost = tots_pkg::NO_CAND;
        batch_lo = '0;
        batch_hi = '0;
        stall_cnt = '0;
        city_count = tots_pkg::DEF_CITIES;
        stall_limit = tots_pkg::DEF_STALL_LIMIT;
        for (int k = 0; k < 16; k++) city_set[k] = 8'(k * 17);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: right after reset, where results are known by inspection
        add_row(mk_req(tots_pkg::FN_COMMIT, 8'h00, 8'h00, 16'h0000, 1'b1), 1'b1, zero_res);
        add_row(mk_req(FN_SPARE6, 8'hFF, 8'hFF, 16'hFFFF, 1'b1), 1'b1, zero_res);
        add_row(mk_req(FN_SPARE7, 8'h00, 8'h00, 16'h0000, 1'b0), 1'b1, zero_res);
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd5, 8'd5, 16'h0000, 1'b0), 1'b1, sat_res);
        add_row(mk_req(tots_pkg::FN_OFFER, 8'hFF, 8'h00, 16'h0000, 1'b0), 1'b1, sat_res);
        add_row(mk_req(tots_pkg::FN_LOAD_DIST, 8'hFF, 8'hFF, 16'hFFFF, 1'b0), 1'b1,
                zero_res);
        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        dir_rows.delete();

        // Load all 256 tour slots and every pair of the city set, symmetric
        for (int i = 0; i < 256; i++)
            send_req(mk_req(tots_pkg::FN_LOAD_CITY, 8'(i), 8'($urandom),
                            {8'($urandom), city_set[4'($urandom_range(0, 15))]},
                            1'($urandom)));
        for (int i = 0; i < 16; i++) begin
            for (int j = i; j < 16; j++) begin
                d = (i == j) ? 16'd0 : ($urandom_range(0, 9) == 0 ? 16'hFFFF : 16'($urandom));
                send_req(mk_req(tots_pkg::FN_LOAD_DIST, city_set[i], city_set[j], d, 1'b0));
                if (i != j)
                    send_req(mk_req(tots_pkg::FN_LOAD_DIST, city_set[j], city_set[i], d,
                                    1'b0));
            end
        end

        // Directed: a full batch cycle checked against the shadow state
        add_row(mk_req(tots_pkg::FN_COST, 8'h00, 8'h00, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd0, 8'd255, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd0, 8'd1, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd254, 8'd255, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd3, 8'd200, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_COMMIT, 8'h00, 8'h00, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd10, 8'd20, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd10, 8'd20, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_COMMIT, 8'h00, 8'h00, 16'h0000, 1'b1));
        add_row(mk_req(tots_pkg::FN_COMMIT, 8'h00, 8'h00, 16'h0000, 1'b1));
        add_row(mk_req(tots_pkg::FN_READ_BEST, 8'd0, 8'h00, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_READ_BEST, 8'd255, 8'h00, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_LOAD_CITY, 8'd255, 8'h00, {8'hFF, city_set[15]}, 1'b0));
        add_row(mk_req(tots_pkg::FN_COST, 8'h00, 8'h00, 16'h0000, 1'b0));
        add_row(mk_req(tots_pkg::FN_OFFER, 8'd1, 8'd255, 16'h0000, 1'b1));
        foreach (dir_rows[i]) send_req(dir_rows[i].req);
        drain();

        // Random phases: reconfigure while idle, restart with a cost pass,
        // then mostly offer batches and commits
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: cities = 9'd3;
                1: cities = 9'd256;
                2: cities = 9'd4;
                default: cities = 9'($urandom_range(5, 255));
            endcase
            case (p % 4)
                0: lim = 16'd1;
                1: lim = 16'hFFFF;
                2: lim = 16'd3;
                default: lim = 16'($urandom_range(2, 40));
            endcase
            write_cfg(tots_pkg::CFG_NUM_CITIES, {7'd0, cities});
            write_cfg(tots_pkg::CFG_STALL_LIMIT, lim);
            send_req(mk_req(tots_pkg::FN_COST, 8'($urandom), 8'($urandom), 16'($urandom),
                            1'($urandom)));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) send_req(random_req());
            drain();
        end

        $display("covered %0d results (%0d offers, %0d commits) over %0d configurations",
                 results_seen, offers_sent, commits_sent, PHASES);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #250_000_000;
        $display("timeout with %0d results pending", pending_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
